/* rtl/backward_lz_bit_decompressor_macros.svh */
// Assertion macros
`ifndef BACKWARD_LZ_BIT_DECOMPRESSOR_MACROS_SVH
`define BACKWARD_LZ_BIT_DECOMPRESSOR_MACROS_SVH
`define BLZ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/blzd_pkg.sv */
package blzd_pkg;
  typedef enum logic [2:0] {
    MODE_PREFIX = 3'd0, MODE_LITLEN_SHORT = 3'd1, MODE_LITLEN_LONG = 3'd2,
    MODE_MATCHLEN = 3'd3, MODE_OFFSET = 3'd4, MODE_LITERAL = 3'd5, MODE_COPY = 3'd6
  } mode_e;
  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_CSUM = 2'd1;
  localparam logic [1:0] PH_CHUNK = 2'd2;
  localparam logic [1:0] PH_DECODE = 2'd3;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;
  localparam logic [31:0] SENTINEL = 32'h8000_0000;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic [31:0] out_position;
    logic       last;
    logic       need_word;
    logic       check_ok;
    logic       overrun;
    logic       misuse;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch a new transaction
    logic step;    // perform one bit/byte step
    logic finish;  // capture result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;    // transaction resolved
  } status_t;
endpackage

/* rtl/blzd_if.sv */
interface blzd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] packed_word;
  modport source (output valid, operation, packed_word, input ready);
  modport sink (input valid, operation, packed_word, output ready);
endinterface

interface blzd_out_if;
  import blzd_pkg::*;
  logic    valid;
  logic    ready;
  result_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

/* rtl/blzd_ctrl.sv */
module blzd_ctrl import blzd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t stat_i
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_RUN = 3'b010, ST_OUT = 3'b100
  } state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (stat_i.done) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  `include "backward_lz_bit_decompressor_macros.svh"
  `BLZ_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `BLZ_ASSERT_NEXT(a_start, clk_i, rst_ni, cmd_o.start, state_q == ST_RUN, "start lost")
  `BLZ_ASSERT(a_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while holding")
endmodule

/* rtl/blzd_datapath.sv */
module blzd_datapath import blzd_pkg::*; #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        operation_i,
  input  logic [31:0] packed_word_i,
  output status_t     stat_o,
  output result_t     res_o
);
  localparam int HW = $clog2(HISTORY_DEPTH);

  logic [1:0]  phase_q;
  logic [31:0] chunk_q, csum_q, left_q;
  mode_e       mode_q;
  logic [11:0] acc_q, dist_q;
  logic [3:0]  fbl_q;
  logic [8:0]  run_q;
  logic [HW-1:0] hp_q;
  logic        op_q;
  logic [31:0] word_q;
  result_t     res_q;
  // clearing sweep of history
  logic        clr_q;
  logic [HW-1:0] clr_addr_q;
  // copy pipeline: 0 = issue read, 1 = data ready
  logic        rd_wait_q;
  logic [7:0]  mem [HISTORY_DEPTH];
  logic [7:0]  rd_q;

  // per-step combinational evaluation
  logic        bitv, done, emit;
  logic [11:0] acc_n;
  result_t     r;

  logic [1:0]  phase_d;
  logic [31:0] chunk_d, csum_d, left_d;
  mode_e       mode_d;
  logic [11:0] acc_d, dist_d;
  logic [3:0]  fbl_d;
  logic [8:0]  run_d;
  logic [HW-1:0] hp_d;
  logic        we, clr_start, rd_issue;
  logic [7:0]  wdata, pbyte;
  logic [HW-1:0] raddr;
  logic        put, feed;

  always_comb begin
    phase_d = phase_q; chunk_d = chunk_q; csum_d = csum_q; left_d = left_q;
    mode_d = mode_q; acc_d = acc_q; dist_d = dist_q; fbl_d = fbl_q; run_d = run_q;
    hp_d = hp_q; we = 1'b0; wdata = '0; clr_start = 1'b0; rd_issue = 1'b0;
    raddr = hp_q + HW'(dist_q);
    done = 1'b0; emit = 1'b0; r = res_q; put = 1'b0; pbyte = '0; feed = 1'b0;
    bitv = 1'b0; acc_n = '0;
    if (cmd_i.step && !clr_q) begin
      if (op_q == OP_LOAD) begin
        done = 1'b1;
        unique case (phase_q)
          PH_SIZE: begin
            left_d = word_q;
            hp_d = (word_q != 0) ? HW'(word_q - 32'd1) : '0;
            phase_d = PH_CSUM; clr_start = 1'b1;
          end
          PH_CSUM: begin csum_d = word_q; phase_d = PH_CHUNK; end
          PH_CHUNK: begin
            chunk_d = word_q; csum_d = csum_q ^ word_q;
            mode_d = MODE_PREFIX; acc_d = '0; fbl_d = '0; run_d = '0; dist_d = '0;
            if (left_q == 0) begin
              r.last = 1'b1; r.check_ok = ((csum_q ^ word_q) == 0); phase_d = PH_SIZE;
            end else phase_d = PH_DECODE;
          end
          default: begin
            if (mode_q != MODE_COPY && chunk_q[31:1] == 0) begin
              csum_d = csum_q ^ word_q;
              chunk_d = (word_q >> 1) | SENTINEL;
              feed = 1'b1; bitv = word_q[0];
            end else r.misuse = 1'b1;
          end
        endcase
      end else if (phase_q != PH_DECODE) begin
        done = 1'b1;
      end else if (mode_q == MODE_COPY) begin
        if (!rd_wait_q) rd_issue = 1'b1;
        else begin
          done = 1'b1; emit = 1'b1; put = 1'b1;
          pbyte = (dist_q != 0) ? rd_q : 8'd0;
          run_d = run_q - 9'd1;
          if (run_q == 9'd1) begin mode_d = MODE_PREFIX; acc_d = '0; fbl_d = '0; end
        end
      end else if (chunk_q[31:1] == 0) begin
        done = 1'b1;
      end else begin
        feed = 1'b1; bitv = chunk_q[0]; chunk_d = chunk_q >> 1;
      end

      if (feed) begin
        acc_n = {acc_q[10:0], bitv};
        acc_d = acc_n;
        if (mode_q == MODE_PREFIX) begin
          fbl_d = fbl_q + 4'd1;
          if (fbl_q == 4'd1 && !acc_n[1]) begin
            acc_d = '0;
            if (!acc_n[0]) begin mode_d = MODE_LITLEN_SHORT; fbl_d = 4'd3; end
            else begin run_d = 9'd2; mode_d = MODE_OFFSET; fbl_d = 4'd8; end
          end else if (fbl_q >= 4'd2) begin
            acc_d = '0;
            unique case (acc_n[1:0])
              2'd3: begin mode_d = MODE_LITLEN_LONG; fbl_d = 4'd8; end
              2'd2: begin mode_d = MODE_MATCHLEN; fbl_d = 4'd8; end
              default: begin
                run_d = {7'd0, acc_n[1:0]} + 9'd3; mode_d = MODE_OFFSET;
                fbl_d = {2'd0, acc_n[1:0]} + 4'd9;
              end
            endcase
          end
        end else begin
          fbl_d = (fbl_q > 0) ? fbl_q - 4'd1 : 4'd0;
          if (fbl_d == 0) begin
            acc_d = '0;
            unique case (mode_q)
              MODE_LITLEN_SHORT: begin
                run_d = {6'd0, acc_n[2:0]} + 9'd1; mode_d = MODE_LITERAL; fbl_d = 4'd8;
              end
              MODE_LITLEN_LONG: begin
                run_d = {1'b0, acc_n[7:0]} + 9'd9; mode_d = MODE_LITERAL; fbl_d = 4'd8;
              end
              MODE_MATCHLEN: begin
                run_d = {1'b0, acc_n[7:0]} + 9'd1; mode_d = MODE_OFFSET; fbl_d = 4'd12;
              end
              MODE_OFFSET: begin dist_d = acc_n; mode_d = MODE_COPY; acc_d = acc_n; end
              MODE_LITERAL: begin
                run_d = run_q - 9'd1; fbl_d = 4'd8;
                if (run_q == 9'd1) begin mode_d = MODE_PREFIX; fbl_d = '0; end
                put = 1'b1; pbyte = acc_n[7:0]; emit = 1'b1; done = 1'b1;
              end
              default: begin mode_d = MODE_PREFIX; fbl_d = '0; end
            endcase
          end
        end
      end

      if (put) begin
        we = 1'b1; wdata = pbyte;
        r.byte_valid = 1'b1; r.out_byte = pbyte; r.out_position = left_q - 32'd1;
        hp_d = hp_q - HW'(1);
        left_d = left_q - 32'd1;
        if (left_q == 32'd1) begin
          r.last = 1'b1; r.check_ok = (csum_d == 0); r.overrun = (run_d != 0);
          phase_d = PH_SIZE; run_d = '0; mode_d = MODE_PREFIX; acc_d = '0; fbl_d = '0;
        end
      end
      if (done && !emit)
        r.need_word = (phase_d != PH_DECODE) ||
                      (mode_d != MODE_COPY && chunk_d[31:1] == 0);
    end
  end

  assign stat_o.done = done;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE; chunk_q <= '0; csum_q <= '0; left_q <= '0;
      mode_q <= MODE_PREFIX; acc_q <= '0; dist_q <= '0; fbl_q <= '0; run_q <= '0;
      hp_q <= '0; clr_q <= 1'b1; clr_addr_q <= '0; rd_wait_q <= 1'b0;
    end else begin
      if (cmd_i.start) rd_wait_q <= 1'b0;
      else rd_wait_q <= rd_issue;
      if (cmd_i.step) begin
        phase_q <= phase_d; chunk_q <= chunk_d; csum_q <= csum_d; left_q <= left_d;
        mode_q <= mode_d; acc_q <= acc_d; dist_q <= dist_d; fbl_q <= fbl_d;
        run_q <= run_d; hp_q <= hp_d;
      end
      if (clr_start) begin clr_q <= 1'b1; clr_addr_q <= '0; end
      else if (clr_q) begin
        clr_addr_q <= clr_addr_q + HW'(1);
        if (clr_addr_q == HW'(HISTORY_DEPTH - 1)) clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin op_q <= operation_i; word_q <= packed_word_i; res_q <= '0; end
    else if (cmd_i.finish) res_q <= r;
    if (clr_q) mem[clr_addr_q] <= 8'd0;
    else if (we) mem[hp_q] <= wdata;
    rd_q <= mem[raddr];
  end

  `include "backward_lz_bit_decompressor_macros.svh"
  `BLZ_ASSERT(a_put_decode, clk_i, rst_ni, !put || phase_q == PH_DECODE, "byte out of decode")
  `BLZ_ASSERT(a_nostep_clr, clk_i, rst_ni, !(done && clr_q), "done during clear")
  `BLZ_ASSERT_NEXT(a_rd, clk_i, rst_ni, rd_issue, rd_wait_q, "read wait lost")
endmodule

/* rtl/backward_lz_bit_decompressor.sv */
// Backward LZ (ByteKiller-style) decompressor. Each input transaction is a word load
// (operation 0) or a byte request (operation 1); each yields one result transaction.
// Bits are parsed one per cycle by the datapath under a small controller, except while
// the history sweep holds the steps; a byte request consumes code bits (up to about 23
// for a match header, 8 per literal byte) and then a handshake; a word load needs no
// bit loop, only its own step plus the handshake; a match copy byte first issues a
// registered history memory read and emits the byte once the data is ready. After reset
// and after every size word the HISTORY_DEPTH-entry history is zero-swept, one entry a
// cycle, before the next transaction completes.
module backward_lz_bit_decompressor import blzd_pkg::*; #(
  parameter int HISTORY_DEPTH = 4096
) (
  input logic   clk_i,
  input logic   rst_ni,
  blzd_in_if.sink    in_if,
  blzd_out_if.source out_if
);
  cmd_t    cmd;
  status_t stat;

  // sequencer: accept, step until resolved, hold result
  blzd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .stat_i(stat)
  );

  // bit parser, counters, checksum and history
  blzd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .operation_i(in_if.operation), .packed_word_i(in_if.packed_word),
    .stat_o(stat), .res_o(out_if.res)
  );
endmodule

/* bench/backward_lz_bit_decompressor_test.sv */
module backward_lz_bit_decompressor_test import blzd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST = 4096;
  // Idle limit: covers the history sweep after each size word plus a full-length
  // match header and the longest receiver stall, several times over.
  localparam int IDLE_LIMIT = 60000;
  localparam int TARGET_ITEMS = 1000;

  // Decoder state as the bench tracks it.
  typedef struct {
    logic [1:0]  phase;
    logic [31:0] chunk;
    logic [31:0] csum;
    logic [31:0] left;
    mode_e       mode;
    logic [11:0] acc;
    logic [3:0]  nbits;
    logic [8:0]  run;
    logic [11:0] match_off;
    logic [11:0] hptr;
    logic [7:0]  hist [HIST];
  } dec_state_t;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
  } item_t;

  logic clk_i;
  logic rst_ni;

  blzd_in_if  in_if ();
  blzd_out_if out_if ();

  backward_lz_bit_decompressor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  item_t      pending_q [$];   // transactions waiting for the driver
  result_t    byte_q [$];      // predicted result transactions, oldest first
  dec_state_t gen_st;          // state used while building stimulus
  dec_state_t chk_st;          // state advanced on accepted transactions
  int         errors;
  int         idle_cycles;
  logic       in_taken;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic start_field(ref dec_state_t s, input mode_e m, input logic [3:0] n);
    s.mode  = m;
    s.acc   = '0;
    s.nbits = n;
  endtask

  // s.run already counts the bytes that remain after this one
  task automatic write_byte(ref dec_state_t s, input logic [7:0] b, inout result_t r);
    r.byte_valid   = 1'b1;
    r.out_byte     = b;
    r.out_position = s.left - 32'd1;
    s.hist[s.hptr] = b;
    s.hptr         = s.hptr - 12'd1;
    s.left         = s.left - 32'd1;
    if (s.left == 0) begin
      r.last     = 1'b1;
      r.check_ok = (s.csum == 0);
      r.overrun  = (s.run != 0);
      s.phase    = PH_SIZE;
      s.run      = '0;
      start_field(s, MODE_PREFIX, 4'd0);
    end
  endtask

  task automatic shift_in_bit(ref dec_state_t s, input logic bit_in, inout result_t r,
                              output bit produced);
    logic [11:0] v;
    produced = 0;
    s.acc = {s.acc[10:0], bit_in};
    if (s.mode == MODE_PREFIX) begin
      s.nbits = s.nbits + 4'd1;
      if (s.nbits == 2 && s.acc[11:1] == 0) begin
        if (s.acc == 0) begin
          start_field(s, MODE_LITLEN_SHORT, 4'd3);
        end else begin
          s.run = 9'd2;
          start_field(s, MODE_OFFSET, 4'd8);
        end
      end else if (s.nbits >= 3) begin
        case (s.acc[1:0])
          2'd3: start_field(s, MODE_LITLEN_LONG, 4'd8);
          2'd2: start_field(s, MODE_MATCHLEN, 4'd8);
          default: begin
            s.run = 9'(s.acc[1:0]) + 9'd3;
            start_field(s, MODE_OFFSET, 4'(s.acc[1:0]) + 4'd9);
          end
        endcase
      end
      return;
    end
    if (s.nbits > 0) s.nbits = s.nbits - 4'd1;
    if (s.nbits != 0) return;
    v = s.acc;
    case (s.mode)
      MODE_LITLEN_SHORT: begin
        s.run = 9'd1 + 9'(v[2:0]);
        start_field(s, MODE_LITERAL, 4'd8);
      end
      MODE_LITLEN_LONG: begin
        s.run = 9'd9 + 9'(v[7:0]);
        start_field(s, MODE_LITERAL, 4'd8);
      end
      MODE_MATCHLEN: begin
        s.run = 9'd1 + 9'(v[7:0]);
        start_field(s, MODE_OFFSET, 4'd12);
      end
      MODE_OFFSET: begin
        s.match_off = v;
        s.mode = MODE_COPY;
      end
      MODE_LITERAL: begin
        s.run = s.run - 9'd1;
        if (s.run == 0) start_field(s, MODE_PREFIX, 4'd0);
        else start_field(s, MODE_LITERAL, 4'd8);
        write_byte(s, v[7:0], r);
        produced = 1;
      end
      default: start_field(s, MODE_PREFIX, 4'd0);
    endcase
  endtask

  function automatic bit wants_word(dec_state_t s);
    return s.phase != PH_DECODE || (s.mode != MODE_COPY && s.chunk[31:1] == 0);
  endfunction

  task automatic decode_step(ref dec_state_t s, input logic op, input logic [31:0] w,
                             output result_t r);
    bit produced;
    logic [7:0] b;
    r = '0;
    produced = 0;
    if (op == OP_LOAD) begin
      case (s.phase)
        PH_SIZE: begin
          s.left = w;
          for (int i = 0; i < HIST; i++) s.hist[i] = '0;
          s.hptr  = (w != 0) ? 12'(w - 32'd1) : 12'd0;
          s.phase = PH_CSUM;
        end
        PH_CSUM: begin
          s.csum  = w;
          s.phase = PH_CHUNK;
        end
        PH_CHUNK: begin
          s.chunk = w;
          s.csum  = s.csum ^ w;
          start_field(s, MODE_PREFIX, 4'd0);
          s.run  = '0;
          s.match_off = '0;
          if (s.left == 0) begin
            // empty stream ends on its first chunk
            r.last     = 1'b1;
            r.check_ok = (s.csum == 0);
            s.phase    = PH_SIZE;
          end else begin
            s.phase = PH_DECODE;
          end
        end
        default: begin
          if (s.mode != MODE_COPY && s.chunk[31:1] == 0) begin
            s.csum  = s.csum ^ w;
            s.chunk = {1'b1, w[31:1]};
            shift_in_bit(s, w[0], r, produced);
          end else begin
            r.misuse = 1'b1;
          end
        end
      endcase
    end else if (s.phase == PH_DECODE) begin
      forever begin
        if (s.mode == MODE_COPY) begin
          b = (s.match_off != 0) ? s.hist[s.hptr + s.match_off] : 8'd0;
          s.run = s.run - 9'd1;
          if (s.run == 0) start_field(s, MODE_PREFIX, 4'd0);
          write_byte(s, b, r);
          produced = 1;
          break;
        end
        if (s.chunk[31:1] == 0) break;
        b[0] = s.chunk[0];
        s.chunk = s.chunk >> 1;
        shift_in_bit(s, b[0], r, produced);
        if (produced) break;
      end
    end
    if (!produced) r.need_word = wants_word(s);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic op, input logic [31:0] w);
    result_t dummy;
    item_t   it;
    decode_step(gen_st, op, w, dummy);
    it.op   = op;
    it.word = w;
    pending_q.insert(pending_q.size(), it);
  endtask

  // One stream: size word, checksum word, then chunk words on demand. With
  // good_sum set, the checksum word is chosen so the stream ends with a zero sum.
  // noise_pct adds needless loads and stray byte requests.
  task automatic play_stream(input logic [31:0] size, input bit good_sum,
                             input int noise_pct, input logic [31:0] first_word);
    logic [31:0] words [256];
    logic [31:0] sum;
    dec_state_t  trial;
    result_t     dummy;
    int          idx;
    words[0] = first_word;
    for (int i = 1; i < 256; i++) words[i] = $urandom;
    sum = $urandom;
    if (good_sum) begin
      trial = gen_st;
      decode_step(trial, OP_LOAD, size, dummy);
      decode_step(trial, OP_LOAD, 32'd0, dummy);
      decode_step(trial, OP_LOAD, words[0], dummy);
      sum = words[0];
      idx = 1;
      while (trial.phase == PH_DECODE) begin
        if (wants_word(trial)) begin
          decode_step(trial, OP_LOAD, words[idx], dummy);
          sum = sum ^ words[idx];
          idx = (idx + 1) % 256;
        end else begin
          decode_step(trial, OP_BYTE, 32'd0, dummy);
        end
      end
    end
    if ($urandom_range(0, 99) < noise_pct) push_item(OP_BYTE, $urandom);
    push_item(OP_LOAD, size);
    push_item(OP_LOAD, sum);
    push_item(OP_LOAD, words[0]);
    idx = 1;
    while (gen_st.phase == PH_DECODE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if (wants_word(gen_st)) push_item(OP_BYTE, $urandom);
        else push_item(OP_LOAD, $urandom);
      end else if (wants_word(gen_st)) begin
        push_item(OP_LOAD, words[idx]);
        idx = (idx + 1) % 256;
      end else begin
        push_item(OP_BYTE, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
    if (got.out_byte !== want.out_byte) report_mismatch("out_byte", got.out_byte, want.out_byte);
    if (got.out_position !== want.out_position)
      report_mismatch("out_position", got.out_position, want.out_position);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    if (got.need_word !== want.need_word)
      report_mismatch("need_word", got.need_word, want.need_word);
    if (got.check_ok !== want.check_ok) report_mismatch("check_ok", got.check_ok, want.check_ok);
    if (got.overrun !== want.overrun) report_mismatch("overrun", got.overrun, want.overrun);
    if (got.misuse !== want.misuse) report_mismatch("misuse", got.misuse, want.misuse);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Valid stays up
  // until the current transaction is taken.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  initial begin
    in_if.valid       = 1'b0;
    in_if.operation   = OP_LOAD;
    in_if.packed_word = '0;
    out_if.ready      = 1'b0;
    burst_left        = 0;
    gap_left          = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) void'(pending_q.pop_front());
      if (in_if.valid && !in_taken) begin
        // still waiting on the sink, hold the transaction
      end else if (pending_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid       <= 1'b1;
        in_if.operation   <= pending_q[0].op;
        in_if.packed_word <= pending_q[0].word;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          // a third of the bursts run back to back
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: duty pattern that changes every so often, sometimes always ready.
  int rx_period;
  int rx_duty;
  int rx_count;

  initial begin
    rx_period = 1;
    rx_duty   = 1;
    rx_count  = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_count <= rx_count + 1;
      if (rx_count % 256 == 255) begin
        rx_period <= $urandom_range(1, 12);
        rx_duty   <= $urandom_range(0, 3) == 0 ? 12 : $urandom_range(1, 12);
      end
      out_if.ready <= (rx_count % rx_period) < rx_duty;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted input, checks each accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        decode_step(chk_st, in_if.operation, in_if.packed_word, want);
        byte_q.insert(byte_q.size(), want);
      end
      if (out_if.valid && out_if.ready) begin
        if (byte_q.size() == 0) begin
          report_mismatch("result count", 32'd1, 32'd0);
        end else begin
          compare_result(out_if.res, byte_q.pop_front());
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  task automatic clear_state(ref dec_state_t s);
    s.phase = PH_SIZE;
    s.chunk = '0;
    s.csum  = '0;
    s.left  = '0;
    s.mode  = MODE_PREFIX;
    s.acc   = '0;
    s.nbits = '0;
    s.run   = '0;
    s.match_off = '0;
    s.hptr  = '0;
    for (int i = 0; i < HIST; i++) s.hist[i] = '0;
  endtask

  initial begin
    logic [31:0] size;
    errors = 0;
    clear_state(gen_st);
    clear_state(chk_st);

    // directed: byte request before any stream, then an empty stream
    push_item(OP_BYTE, 32'hFFFF_FFFF);
    push_item(OP_LOAD, 32'd0);
    push_item(OP_LOAD, 32'h5A5A_5A5A);
    push_item(OP_LOAD, 32'h5A5A_5A5A);
    // all-ones chunk: long literal run cut short by a tiny size (overrun)
    play_stream(32'd3, 1'b0, 0, 32'hFFFF_FFFF);
    // sentinel-only chunk: the first request already needs a word
    play_stream(32'd2, 1'b1, 0, 32'h0000_0001);
    // zero chunk, and stray loads and requests mixed in
    play_stream(32'd4, 1'b1, 40, 32'h0000_0000);
    play_stream(32'd1, 1'b1, 0, 32'hAAAA_AAAA);

    // random streams, mostly well formed with a zero checksum
    while (pending_q.size() < TARGET_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       size = 32'd0;
        1:       size = $urandom_range(100, 300);
        2:       size = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'd0} | $urandom_range(1, 8);
        default: size = $urandom_range(1, 40);
      endcase
      // very large sizes: keep the stream short by drawing a small size instead
      if (size > 1000) size = $urandom_range(1, 8);
      play_stream(size, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) == 0 ? 8 : 0, $urandom);
    end
    // one huge stated size, then its checksum word, a random chunk and one byte request
    push_item(OP_LOAD, 32'hFFFF_FFFF);
    push_item(OP_LOAD, $urandom);
    push_item(OP_LOAD, $urandom);
    push_item(OP_BYTE, 32'd0);

    wait (rst_ni);
    while (pending_q.size() != 0 || byte_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
